@@ src/csr_rme_pkg.sv @@
// ----------------------------------------------------------------------------
// csr_rme_pkg
// Shared types and constants of the CSR residual maximum-error checker.
// ----------------------------------------------------------------------------
package csr_rme_pkg;

  localparam int unsigned COL_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned MAG_W = 63;
  localparam int unsigned FRAC_W = 16;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NONZERO = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;
  localparam logic [1:0] OP_FINISH  = 2'd3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef logic [1:0] op_t;

  typedef struct packed {
    op_t                      opcode;
    logic [COL_W-1:0]         column_index;
    logic signed [VAL_W-1:0]  operand_value;
    logic signed [VAL_W-1:0]  rhs_value;
  } in_req_t;

  typedef struct packed {
    logic [MAG_W-1:0] max_error;
    logic             saturated;
  } out_rsp_t;

  // Request after the x store read has been issued.
  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic                     in_range;
    logic signed [VAL_W-1:0]  val;
    logic signed [VAL_W-1:0]  rhs;
  } rd_stage_t;

  // Request after row accumulation, heading into the max tracker.
  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic signed [ACC_W-1:0]  diff;
    logic                     sat;
  } red_stage_t;

endpackage

@@ src/csr_rme_xmem.sv @@
// ----------------------------------------------------------------------------
// csr_rme_xmem
// Solution vector store: one write port, one synchronous read port.
// ----------------------------------------------------------------------------
module csr_rme_xmem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic [csr_rme_pkg::VAL_W-1:0]     wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic [csr_rme_pkg::VAL_W-1:0]     rd_data
);

  logic [csr_rme_pkg::VAL_W-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

endmodule

@@ src/csr_rme_accum.sv @@
// ----------------------------------------------------------------------------
// csr_rme_accum
// Product register and saturating row accumulator; forms the row residual.
// ----------------------------------------------------------------------------
module csr_rme_accum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  csr_rme_pkg::rd_stage_t              rd_stage,
  input  logic [csr_rme_pkg::VAL_W-1:0]       x_data,
  output csr_rme_pkg::red_stage_t             red_stage
);

  logic                                   mul_valid;
  csr_rme_pkg::op_t                       mul_op;
  logic signed [csr_rme_pkg::ACC_W-1:0]   mul_prod;
  logic signed [csr_rme_pkg::VAL_W-1:0]   mul_rhs;
  logic signed [csr_rme_pkg::ACC_W-1:0]   row_sum;
  logic signed [csr_rme_pkg::ACC_W-1:0]   row_sum_next;
  csr_rme_pkg::red_stage_t                red_stage_next;

  logic signed [csr_rme_pkg::VAL_W-1:0]   x_op;
  logic signed [csr_rme_pkg::ACC_W-1:0]   prod;
  logic signed [csr_rme_pkg::ACC_W-1:0]   rhs_wide;
  logic signed [csr_rme_pkg::ACC_W-1:0]   sum;
  logic signed [csr_rme_pkg::ACC_W-1:0]   dif;
  logic signed [csr_rme_pkg::ACC_W-1:0]   sat_val;
  logic                                   add_ovf;
  logic                                   sub_ovf;

  assign x_op = rd_stage.in_range ? $signed(x_data) : '0;
  assign prod = rd_stage.val * x_op;

  assign rhs_wide = {{(csr_rme_pkg::ACC_W - csr_rme_pkg::VAL_W - csr_rme_pkg::FRAC_W)
                      {mul_rhs[csr_rme_pkg::VAL_W-1]}},
                     mul_rhs, {csr_rme_pkg::FRAC_W{1'b0}}};
  assign sum     = row_sum + mul_prod;
  assign dif     = row_sum - rhs_wide;
  assign sat_val = row_sum[csr_rme_pkg::ACC_W-1] ? csr_rme_pkg::ACC_MIN
                                                 : csr_rme_pkg::ACC_MAX;
  assign add_ovf = (row_sum[csr_rme_pkg::ACC_W-1] == mul_prod[csr_rme_pkg::ACC_W-1]) &&
                   (sum[csr_rme_pkg::ACC_W-1] != row_sum[csr_rme_pkg::ACC_W-1]);
  assign sub_ovf = (row_sum[csr_rme_pkg::ACC_W-1] != rhs_wide[csr_rme_pkg::ACC_W-1]) &&
                   (dif[csr_rme_pkg::ACC_W-1] != row_sum[csr_rme_pkg::ACC_W-1]);

  always_comb begin
    row_sum_next         = row_sum;
    red_stage_next.valid = mul_valid;
    red_stage_next.op    = mul_op;
    red_stage_next.diff  = '0;
    red_stage_next.sat   = 1'b0;
    if (mul_valid) begin
      unique case (mul_op)
        csr_rme_pkg::OP_NONZERO: begin
          row_sum_next       = add_ovf ? sat_val : sum;
          red_stage_next.sat = add_ovf;
        end
        csr_rme_pkg::OP_CLOSE: begin
          red_stage_next.diff = sub_ovf ? sat_val : dif;
          red_stage_next.sat  = sub_ovf;
          row_sum_next        = '0;
        end
        default: begin
          row_sum_next = row_sum;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid       <= 1'b0;
      row_sum         <= '0;
      red_stage.valid <= 1'b0;
    end else if (adv) begin
      mul_valid       <= rd_stage.valid;
      row_sum         <= row_sum_next;
      red_stage.valid <= red_stage_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_op         <= rd_stage.op;
      mul_prod       <= prod;
      mul_rhs        <= rd_stage.rhs;
      red_stage.op   <= red_stage_next.op;
      red_stage.diff <= red_stage_next.diff;
      red_stage.sat  <= red_stage_next.sat;
    end
  end

endmodule

@@ src/csr_rme_report.sv @@
// ----------------------------------------------------------------------------
// csr_rme_report
// Absolute residual, running maximum, sticky saturation and result register.
// ----------------------------------------------------------------------------
module csr_rme_report (
  input  logic                      clk,
  input  logic                      rst,
  input  csr_rme_pkg::red_stage_t   red_stage,
  output logic                      hold,
  output logic                      out_valid,
  input  logic                      out_ready,
  output csr_rme_pkg::out_rsp_t     out_data
);

  logic [csr_rme_pkg::MAG_W-1:0]         running_max;
  logic [csr_rme_pkg::MAG_W-1:0]         running_max_next;
  logic                                  sat_seen;
  logic                                  sat_seen_next;
  logic [csr_rme_pkg::MAG_W-1:0]         mag;
  logic signed [csr_rme_pkg::ACC_W-1:0]  neg_diff;
  logic                                  clamp;
  logic                                  fire;

  assign fire = red_stage.valid && (red_stage.op == csr_rme_pkg::OP_FINISH);
  assign hold = fire && out_valid && !out_ready;

  assign neg_diff = -red_stage.diff;

  always_comb begin
    clamp = 1'b0;
    if (red_stage.diff == csr_rme_pkg::ACC_MIN) begin
      mag   = csr_rme_pkg::MAG_MAX;
      clamp = 1'b1;
    end else if (red_stage.diff[csr_rme_pkg::ACC_W-1]) begin
      mag = neg_diff[csr_rme_pkg::MAG_W-1:0];
    end else begin
      mag = red_stage.diff[csr_rme_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    running_max_next = running_max;
    sat_seen_next    = sat_seen;
    if (red_stage.valid) begin
      priority if (fire) begin
        running_max_next = '0;
        sat_seen_next    = 1'b0;
      end else if (red_stage.op == csr_rme_pkg::OP_CLOSE) begin
        if (mag > running_max) begin
          running_max_next = mag;
        end
        sat_seen_next = sat_seen | red_stage.sat | clamp;
      end else begin
        sat_seen_next = sat_seen | red_stage.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      sat_seen    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (!hold) begin
        running_max <= running_max_next;
        sat_seen    <= sat_seen_next;
        if (fire) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !hold) begin
      out_data.max_error <= running_max;
      out_data.saturated <= sat_seen;
    end
  end

endmodule

@@ src/csr_residual_max_error.sv @@
// ----------------------------------------------------------------------------
// csr_residual_max_error
// Largest absolute row residual |A*x - b| of a CSR system streamed row by row.
// ----------------------------------------------------------------------------
// Takes one request per cycle. Load requests write x into an on-chip store;
// nonzero requests read it (one synchronous read), multiply and accumulate
// into a saturating Q32.32 row sum; close-row requests fold the row residual
// into a running maximum; a finish request posts the maximum and a sticky
// saturation flag to a result register through the read, product and row stages. The
// pipeline stalls only while a finish result reaches a still occupied result
// register. No clearing pass follows reset: x entries are valid once loaded.
module csr_residual_max_error #(
  parameter int unsigned VECTOR_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  csr_rme_pkg::in_req_t    in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output csr_rme_pkg::out_rsp_t   out_data
);

  localparam int unsigned AW    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int unsigned EXT_W = 17;

  logic                                   adv;
  logic                                   hold;
  logic                                   accept;
  logic [EXT_W-1:0]                       col_ext;
  logic                                   in_range;
  logic [AW-1:0]                          addr;
  logic [csr_rme_pkg::VAL_W-1:0]          x_data;
  csr_rme_pkg::rd_stage_t                 rd_stage;
  csr_rme_pkg::red_stage_t                red_stage;

  assign adv      = !hold;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  assign col_ext  = EXT_W'(in_data.column_index);
  assign in_range = col_ext < EXT_W'(VECTOR_DEPTH);
  assign addr     = col_ext[AW-1:0];

  csr_rme_xmem #(
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_xmem (
    .clk     (clk),
    .wr_en   (accept && in_range && (in_data.opcode == csr_rme_pkg::OP_LOAD)),
    .wr_addr (addr),
    .wr_data (in_data.operand_value),
    .rd_en   (accept && in_range && (in_data.opcode == csr_rme_pkg::OP_NONZERO)),
    .rd_addr (addr),
    .rd_data (x_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_stage.valid <= 1'b0;
    end else if (adv) begin
      rd_stage.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_stage.op       <= in_data.opcode;
      rd_stage.in_range <= in_range;
      rd_stage.val      <= in_data.operand_value;
      rd_stage.rhs      <= in_data.rhs_value;
    end
  end

  csr_rme_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .rd_stage  (rd_stage),
    .x_data    (x_data),
    .red_stage (red_stage)
  );

  csr_rme_report u_report (
    .clk       (clk),
    .rst       (rst),
    .red_stage (red_stage),
    .hold      (hold),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CSR residual maximum-error checker.
// ----------------------------------------------------------------------------
// A queue of requests feeds a valid/ready driver. Every accepted request also
// steps a cycle-free model of the row sum, the running maximum and the sticky
// saturation flag. A monitor checks each finish report against the oldest
// expected report. A short directed set covers empty rows, finish in the
// middle of a row, and saturation of the sum, the difference and the absolute
// value. After it come random CSR systems with some noise mixed in, run under
// three idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned PHASE_REQUESTS = 530;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  csr_rme_pkg::in_req_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  csr_rme_pkg::out_rsp_t out_data;

  csr_residual_max_error uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  csr_rme_pkg::in_req_t  pending_requests[$];
  csr_rme_pkg::out_rsp_t expected_reports[$];
  csr_rme_pkg::out_rsp_t front_report;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned requests_queued = 0;
  int unsigned reports_checked = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Generator bookkeeping: x entries already loaded, in queue order.
  bit          x_loaded[DEPTH];
  int unsigned loaded_cols[$];

  // Residual model state.
  logic signed [csr_rme_pkg::VAL_W-1:0] x_mirror[DEPTH];
  logic signed [csr_rme_pkg::ACC_W-1:0] row_acc = '0;
  logic [csr_rme_pkg::MAG_W-1:0]        peak_residual = '0;
  logic                                 sat_seen = 1'b0;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic residual_step(input csr_rme_pkg::in_req_t req);
    logic signed [csr_rme_pkg::VAL_W-1:0] a;
    logic signed [csr_rme_pkg::VAL_W-1:0] xv;
    logic signed [csr_rme_pkg::VAL_W-1:0] r;
    logic signed [csr_rme_pkg::ACC_W:0]   prod;
    logic signed [csr_rme_pkg::ACC_W:0]   wide;
    logic signed [csr_rme_pkg::ACC_W:0]   rhs_wide;
    logic signed [csr_rme_pkg::ACC_W-1:0] diff;
    logic signed [csr_rme_pkg::ACC_W-1:0] neg;
    logic [csr_rme_pkg::MAG_W-1:0]        mag;
    a = req.operand_value;
    r = req.rhs_value;
    case (req.opcode)
      csr_rme_pkg::OP_LOAD: begin
        x_mirror[req.column_index] = a;
      end
      csr_rme_pkg::OP_NONZERO: begin
        xv = x_mirror[req.column_index];
        prod = a * xv;
        wide = row_acc + prod;
        if (wide[csr_rme_pkg::ACC_W] != wide[csr_rme_pkg::ACC_W-1]) begin
          sat_seen = 1'b1;
          row_acc = wide[csr_rme_pkg::ACC_W] ? csr_rme_pkg::ACC_MIN : csr_rme_pkg::ACC_MAX;
        end else begin
          row_acc = wide[csr_rme_pkg::ACC_W-1:0];
        end
      end
      csr_rme_pkg::OP_CLOSE: begin
        rhs_wide = r;
        rhs_wide = rhs_wide <<< csr_rme_pkg::FRAC_W;
        wide = row_acc - rhs_wide;
        if (wide[csr_rme_pkg::ACC_W] != wide[csr_rme_pkg::ACC_W-1]) begin
          sat_seen = 1'b1;
          diff = wide[csr_rme_pkg::ACC_W] ? csr_rme_pkg::ACC_MIN : csr_rme_pkg::ACC_MAX;
        end else begin
          diff = wide[csr_rme_pkg::ACC_W-1:0];
        end
        if (diff == csr_rme_pkg::ACC_MIN) begin
          sat_seen = 1'b1;
          mag = csr_rme_pkg::MAG_MAX;
        end else if (diff[csr_rme_pkg::ACC_W-1]) begin
          neg = -diff;
          mag = neg[csr_rme_pkg::MAG_W-1:0];
        end else begin
          mag = diff[csr_rme_pkg::MAG_W-1:0];
        end
        if (mag > peak_residual) peak_residual = mag;
        row_acc = '0;
      end
      default: begin
        expected_reports.push_back('{max_error: peak_residual, saturated: sat_seen});
        peak_residual = '0;
        sat_seen = 1'b0;
      end
    endcase
  endtask

  task automatic push_req(input csr_rme_pkg::op_t op, input int unsigned col,
                          input logic [31:0] val, input logic [31:0] rhs);
    csr_rme_pkg::in_req_t req;
    req.opcode = op;
    req.column_index = col[csr_rme_pkg::COL_W-1:0];
    req.operand_value = val;
    req.rhs_value = rhs;
    if (op == csr_rme_pkg::OP_LOAD && !x_loaded[col]) begin
      x_loaded[col] = 1'b1;
      loaded_cols.push_back(col);
    end
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  function automatic logic [31:0] pick_q16();
    logic [31:0] s;
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      3, 4: return $urandom();
      default: begin
        s = $urandom_range(0, 32'h000F_FFFF);
        return $urandom_range(0, 1) ? -s : s;
      end
    endcase
  endfunction

  function automatic int unsigned pick_load_col();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return DEPTH - 1;
      default: return $urandom_range(0, DEPTH - 1);
    endcase
  endfunction

  function automatic int unsigned pick_loaded_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  task automatic queue_noise();
    csr_rme_pkg::op_t op;
    int unsigned      col;
    op = csr_rme_pkg::op_t'($urandom_range(0, 3));
    col = (op == csr_rme_pkg::OP_NONZERO) ? pick_loaded_col() : $urandom_range(0, DEPTH - 1);
    push_req(op, col, $urandom(), $urandom());
  endtask

  // One small system: a few x loads, several rows, then a finish.
  task automatic queue_system(input int unsigned rows);
    int unsigned loads;
    int unsigned nnz;
    loads = $urandom_range(1, 6);
    repeat (loads) push_req(csr_rme_pkg::OP_LOAD, pick_load_col(), pick_q16(), $urandom());
    repeat (rows) begin
      nnz = $urandom_range(0, 4);
      repeat (nnz) begin
        push_req(csr_rme_pkg::OP_NONZERO, pick_loaded_col(), pick_q16(), $urandom());
        if ($urandom_range(0, 9) == 0) queue_noise();
      end
      push_req(csr_rme_pkg::OP_CLOSE, $urandom_range(0, DEPTH - 1), $urandom(), pick_q16());
    end
    push_req(csr_rme_pkg::OP_FINISH, $urandom_range(0, DEPTH - 1), $urandom(), $urandom());
  endtask

  task automatic queue_directed();
    push_req(csr_rme_pkg::OP_FINISH, 0, 32'h0, 32'h0);
    push_req(csr_rme_pkg::OP_LOAD, 0, 32'h7FFF_FFFF, 32'h0);
    push_req(csr_rme_pkg::OP_LOAD, DEPTH - 1, 32'h8000_0000, 32'h0);
    push_req(csr_rme_pkg::OP_LOAD, 1, 32'h0001_0000, 32'h0);
    // empty row against the most negative rhs
    push_req(csr_rme_pkg::OP_CLOSE, 0, 32'h0, 32'h8000_0000);
    // finish in the middle of a row keeps the partial sum
    push_req(csr_rme_pkg::OP_NONZERO, 1, 32'h0003_0000, 32'h0);
    push_req(csr_rme_pkg::OP_FINISH, 0, 32'h0, 32'h0);
    push_req(csr_rme_pkg::OP_CLOSE, 0, 32'h0, 32'h0002_0000);
    // sum saturates high, then the difference saturates high
    push_req(csr_rme_pkg::OP_NONZERO, DEPTH - 1, 32'h8000_0000, 32'h0);
    push_req(csr_rme_pkg::OP_NONZERO, DEPTH - 1, 32'h8000_0000, 32'h0);
    push_req(csr_rme_pkg::OP_CLOSE, 0, 32'h0, 32'h8000_0000);
    push_req(csr_rme_pkg::OP_FINISH, 0, 32'h0, 32'h0);
    // sum saturates low, absolute value clamps
    repeat (3) push_req(csr_rme_pkg::OP_NONZERO, DEPTH - 1, 32'h7FFF_FFFF, 32'h0);
    push_req(csr_rme_pkg::OP_CLOSE, 0, 32'h0, 32'h0);
    // difference saturates low
    repeat (3) push_req(csr_rme_pkg::OP_NONZERO, DEPTH - 1, 32'h7FFF_FFFF, 32'h0);
    push_req(csr_rme_pkg::OP_CLOSE, DEPTH - 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    push_req(csr_rme_pkg::OP_FINISH, 0, 32'h0, 32'h0);
    push_req(csr_rme_pkg::OP_NONZERO, 0, 32'h7FFF_FFFF, 32'h0);
    push_req(csr_rme_pkg::OP_CLOSE, 0, 32'h0, 32'h7FFF_FFFF);
    push_req(csr_rme_pkg::OP_FINISH, DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic run_phase(input int unsigned send_idle, input int unsigned recv_idle,
                           input bit directed);
    int unsigned target;
    @(negedge clk);
    sender_idle_pct = send_idle;
    receiver_idle_pct = recv_idle;
    if (directed) queue_directed();
    target = requests_queued + PHASE_REQUESTS;
    while (requests_queued < target) queue_system($urandom_range(1, 6));
    while (pending_requests.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  // Request driver; steps the residual model on each accepted request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) residual_step(in_data);
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Report monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      reports_checked++;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("report with none expected: max_error=%h saturated=%b",
                                  out_data.max_error, out_data.saturated));
      end else begin
        front_report = expected_reports.pop_front();
        if (out_data.max_error !== front_report.max_error)
          report_mismatch($sformatf("report %0d max_error got %h want %h", reports_checked,
                                    out_data.max_error, front_report.max_error));
        if (out_data.saturated !== front_report.saturated)
          report_mismatch($sformatf("report %0d saturated got %b want %b", reports_checked,
                                    out_data.saturated, front_report.saturated));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d reports outstanding", cycle_count,
             expected_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_phase(19, 51, 1'b1);
    run_phase(51, 19, 1'b0);
    run_phase(0, 0, 1'b0);
    repeat (20) @(posedge clk);
    $display("Streamed %0d requests (loads, nonzeros, row closes, finishes) under three",
             requests_queued);
    $display("idle patterns; %0d finish reports checked, %0d mismatches", reports_checked,
             error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
